/* rtl/pva_pkg.sv */
package pva_pkg;

   // Defaults for the top-level parameters
   localparam int CHANNELS_DEF    = 8;
   localparam int SOURCE_BITS_DEF = 16;

   // Fixed field widths
   localparam int OP_W    = 2;
   localparam int CLASS_W = 4;
   localparam int PRIO_W  = 8;
   localparam int REL_W   = 3;
   localparam int CHAN_W  = 3;
   localparam int CFG_W   = 4;

   // Channel count register after reset
   localparam logic [CFG_W-1:0] CSR_RESET = 4'd8;

   // Operation codes carried on req_tuser
   localparam logic [OP_W-1:0] OP_START   = 2'd0;
   localparam logic [OP_W-1:0] OP_STOP    = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

   // Result word: granted, chan, stop_a_valid, stop_a_chan,
   // stop_b_valid, stop_b_chan, cleared_all, then zero fill
   localparam int RSP_BITS = 1 + CHAN_W + 1 + CHAN_W + 1 + CHAN_W + 1;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD  = RSP_W - RSP_BITS;

   // Bit positions of the result flags
   localparam int RSP_GRANT_BIT = 0;
   localparam int RSP_CHAN_LSB  = 1;
   localparam int RSP_SA_V_BIT  = 4;
   localparam int RSP_SA_LSB    = 5;
   localparam int RSP_SB_V_BIT  = 8;
   localparam int RSP_SB_LSB    = 9;
   localparam int RSP_CLR_BIT   = 12;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture the request fields, clear the result
      logic idx_clr;     // scan index back to channel 0
      logic idx_inc;     // scan index to the next channel
      logic free_cur;    // clear busy of the scanned channel
      logic free_rel;    // clear busy of the released channel
      logic set_sa_cur;  // first stop is the scanned channel
      logic set_sa_rel;  // first stop is the released channel
      logic set_sb_cur;  // second stop is the scanned channel
      logic grant_cur;   // give the scanned channel to the new sound
      logic clear_all;   // free every channel
      logic publish;     // move the finished result to the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic cur_busy;    // scanned channel is busy
      logic match_src;   // scanned owner equals the request source
      logic match_full;  // scanned owner and class equal the request
      logic src_nz;      // request source is not zero
      logic prio_hit;    // scanned priority number at least the request's
      logic idx_last;    // scan index is the last live channel
      logic rel_ok;      // release channel is live and busy
   } sts_type;

endpackage

/* rtl/priority_voice_allocator.sv */
// Voice allocator over a table of CHANNELS sound channels.
// Request channel (req_*): req_tuser carries the operation (start, stop by
// source, release, clear all), req_tdata the source id, exclusivity class,
// priority number and release channel. One request is in work at a time;
// req_tready is high only while the block waits for a request.
// Result channel (rsp_*): one transfer per request, with the granted channel,
// up to two stopped channels and the clear-all flag.
// Configuration: csr_we/csr_wdata write the live channel count n.
// Timing: the table is walked one channel per cycle through a single compare
// unit. A start takes up to three walks (stop same source and class, look
// for a free channel, look for one to steal). The result sits in an output
// register; the next request is taken in the cycle after its result is
// published. A further result waits while rsp_tready is low.
// Reset: synchronous, active high; all channels free, n = 8.
module priority_voice_allocator
   import pva_pkg::*;
#(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int SOURCE_BITS = SOURCE_BITS_DEF,
   parameter int REQ_W       = ((SOURCE_BITS + CLASS_W + PRIO_W + REL_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // source_id, excl_class, prio, release_chan
   input  logic [REQ_W-1:0] req_tdata,
   // opcode
   input  logic [OP_W-1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // granted, chan, stop_a_valid, stop_a_chan, stop_b_valid, stop_b_chan,
   // cleared_all
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   pva_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pva_datapath #(
      .CHANNELS    (CHANNELS),
      .SOURCE_BITS (SOURCE_BITS),
      .REQ_W       (REQ_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* rtl/pva_datapath.sv */
module pva_datapath
   import pva_pkg::*;
#(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int SOURCE_BITS = SOURCE_BITS_DEF,
   parameter int REQ_W       = ((SOURCE_BITS + CLASS_W + PRIO_W + REL_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,
   input  cmd_type          cmd,
   output sts_type          sts,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CLOG_CH = $clog2(CHANNELS + 1);
   localparam int CNT_W   = (CLOG_CH > CFG_W) ? CLOG_CH : CFG_W;
   localparam int CLS_LSB = SOURCE_BITS;
   localparam int PRI_LSB = SOURCE_BITS + CLASS_W;
   localparam int REL_LSB = SOURCE_BITS + CLASS_W + PRIO_W;

   // Configuration and channel table
   logic [CFG_W-1:0]       csr_ff, csr_in;
   logic [CHANNELS-1:0]    busy_ff, busy_in;
   logic [SOURCE_BITS-1:0] owner_src_ff   [CHANNELS];
   logic [CLASS_W-1:0]     owner_class_ff [CHANNELS];
   logic [PRIO_W-1:0]      owner_prio_ff  [CHANNELS];

   // Scan index and captured request
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SOURCE_BITS-1:0] src_ff, src_in;
   logic [CLASS_W-1:0]     cls_ff, cls_in;
   logic [PRIO_W-1:0]      prio_ff, prio_in;
   logic [REL_W-1:0]       rel_ff, rel_in;

   // Result being built and the output register
   logic              granted_ff, granted_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic              sa_v_ff, sa_v_in;
   logic [CHAN_W-1:0] sa_c_ff, sa_c_in;
   logic              sb_v_ff, sb_v_in;
   logic [CHAN_W-1:0] sb_c_ff, sb_c_in;
   logic              clr_ff, clr_in;
   logic [RSP_W-1:0]  rsp_ff, rsp_in;

   logic [CNT_W-1:0] cfg_ext;
   logic [CNT_W-1:0] live;
   logic [CNT_W-1:0] last_idx;
   logic [IDX_W-1:0] rel_idx;
   logic [CHAN_W-1:0] idx_chan;

   // Live channel count, clamped to 1..CHANNELS
   always_comb begin
      cfg_ext = CNT_W'(csr_ff);
      priority if (cfg_ext == '0) begin
         live = CNT_W'(1);
      end else if (cfg_ext > CNT_W'(CHANNELS)) begin
         live = CNT_W'(CHANNELS);
      end else begin
         live = cfg_ext;
      end
      last_idx = live - CNT_W'(1);
   end

   assign rel_idx  = IDX_W'(rel_ff);
   assign idx_chan = CHAN_W'(idx_ff);

   // Compare the scanned entry against the request
   always_comb begin
      sts.cur_busy   = busy_ff[idx_ff];
      sts.match_src  = (owner_src_ff[idx_ff] == src_ff);
      sts.match_full = sts.match_src && (owner_class_ff[idx_ff] == cls_ff);
      sts.src_nz     = |src_ff;
      sts.prio_hit   = (owner_prio_ff[idx_ff] >= prio_ff);
      sts.idx_last   = (CNT_W'(idx_ff) == last_idx);
      sts.rel_ok     = (CNT_W'(rel_ff) < live) && busy_ff[rel_idx];
   end

   // Next-state logic
   always_comb begin
      csr_in     = csr_we ? csr_wdata : csr_ff;
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      src_in     = src_ff;
      cls_in     = cls_ff;
      prio_in    = prio_ff;
      rel_in     = rel_ff;
      granted_in = granted_ff;
      chan_in    = chan_ff;
      sa_v_in    = sa_v_ff;
      sa_c_in    = sa_c_ff;
      sb_v_in    = sb_v_ff;
      sb_c_in    = sb_c_ff;
      clr_in     = clr_ff;
      rsp_in     = rsp_ff;

      // capture a new request
      if (cmd.load) begin
         src_in     = req_tdata[SOURCE_BITS-1:0];
         cls_in     = req_tdata[CLS_LSB +: CLASS_W];
         prio_in    = req_tdata[PRI_LSB +: PRIO_W];
         rel_in     = req_tdata[REL_LSB +: REL_W];
         granted_in = 1'b0;
         chan_in    = '0;
         sa_v_in    = 1'b0;
         sa_c_in    = '0;
         sb_v_in    = 1'b0;
         sb_c_in    = '0;
         clr_in     = 1'b0;
      end

      // scan index
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      // busy marks; a grant wins over a free of the same channel
      if (cmd.clear_all) begin
         busy_in = '0;
         clr_in  = 1'b1;
      end
      if (cmd.free_cur) begin
         busy_in[idx_ff] = 1'b0;
      end
      if (cmd.free_rel) begin
         busy_in[rel_idx] = 1'b0;
      end
      if (cmd.grant_cur) begin
         busy_in[idx_ff] = 1'b1;
         granted_in      = 1'b1;
         chan_in         = idx_chan;
      end

      // stop reports
      if (cmd.set_sa_cur) begin
         sa_v_in = 1'b1;
         sa_c_in = idx_chan;
      end else if (cmd.set_sa_rel) begin
         sa_v_in = 1'b1;
         sa_c_in = rel_ff;
      end
      if (cmd.set_sb_cur) begin
         sb_v_in = 1'b1;
         sb_c_in = idx_chan;
      end

      // output register
      if (cmd.publish) begin
         rsp_in = {{RSP_PAD{1'b0}}, clr_ff, sb_c_ff, sb_v_ff, sa_c_ff, sa_v_ff,
                   chan_ff, granted_ff};
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff  <= CSR_RESET;
         busy_ff <= '0;
         idx_ff  <= '0;
      end else begin
         csr_ff  <= csr_in;
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      src_ff     <= src_in;
      cls_ff     <= cls_in;
      prio_ff    <= prio_in;
      rel_ff     <= rel_in;
      granted_ff <= granted_in;
      chan_ff    <= chan_in;
      sa_v_ff    <= sa_v_in;
      sa_c_ff    <= sa_c_in;
      sb_v_ff    <= sb_v_in;
      sb_c_ff    <= sb_c_in;
      clr_ff     <= clr_in;
      rsp_ff     <= rsp_in;
   end

   // Owner table, written at the scan index on a grant
   always_ff @(posedge clock) begin
      if (cmd.grant_cur) begin
         owner_src_ff[idx_ff]   <= src_ff;
         owner_class_ff[idx_ff] <= cls_ff;
         owner_prio_ff[idx_ff]  <= prio_ff;
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

/* rtl/pva_controller.sv */
module pva_controller
   import pva_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [OP_W-1:0] req_tuser,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  sts_type         sts,
   output cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIRST = 3'd1;  // stop lowest same source and class
   localparam logic [2:0] ST_SCAN  = 3'd2;  // look for a free or reusable channel
   localparam logic [2:0] ST_STEAL = 3'd3;  // look for a channel to steal
   localparam logic [2:0] ST_SRC   = 3'd4;  // stop by source
   localparam logic [2:0] ST_REL   = 3'd5;
   localparam logic [2:0] ST_CLR   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Sequencer
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load    = 1'b1;
               cmd.idx_clr = 1'b1;
               unique case (req_tuser)
                  OP_START:   state_in = ST_FIRST;
                  OP_STOP:    state_in = ST_SRC;
                  OP_RELEASE: state_in = ST_REL;
                  OP_CLEAR:   state_in = ST_CLR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIRST: begin
            if (sts.cur_busy && sts.match_full) begin
               cmd.free_cur   = 1'b1;
               cmd.set_sa_cur = 1'b1;
               cmd.idx_clr    = 1'b1;
               state_in       = ST_SCAN;
            end else if (sts.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_SCAN;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!sts.cur_busy) begin
               cmd.grant_cur = 1'b1;
               state_in      = ST_DONE;
            end else if (sts.src_nz && sts.match_full) begin
               // same source still playing this class: reuse it
               cmd.set_sb_cur = 1'b1;
               cmd.grant_cur  = 1'b1;
               state_in       = ST_DONE;
            end else if (sts.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_STEAL;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_STEAL: begin
            if (sts.prio_hit) begin
               cmd.set_sb_cur = 1'b1;
               cmd.grant_cur  = 1'b1;
               state_in       = ST_DONE;
            end else if (sts.idx_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SRC: begin
            if (sts.cur_busy && sts.match_src) begin
               cmd.free_cur   = 1'b1;
               cmd.set_sa_cur = 1'b1;
               state_in       = ST_DONE;
            end else if (sts.idx_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_REL: begin
            if (sts.rel_ok) begin
               cmd.free_rel   = 1'b1;
               cmd.set_sa_rel = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_CLR: begin
            cmd.clear_all = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output valid: set on publish, cleared on transfer
   always_comb begin
      priority if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/pva_checker.sv */
module pva_checker
   import pva_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // One request at a time: after a transfer the block is busy
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in work");

   // Channel field is zero unless granted
   a_chan_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[RSP_GRANT_BIT]) |->
      (rsp_tdata[RSP_CHAN_LSB +: CHAN_W] == '0))
      else $error("channel reported without grant");

   // Stop channel fields are zero unless their valid bit is set
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
      ((rsp_tdata[RSP_SA_V_BIT] || rsp_tdata[RSP_SA_LSB +: CHAN_W] == '0) &&
       (rsp_tdata[RSP_SB_V_BIT] || rsp_tdata[RSP_SB_LSB +: CHAN_W] == '0)))
      else $error("stop channel reported without valid");

   // Clear all reports nothing else
   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_CLR_BIT]) |->
      (!rsp_tdata[RSP_GRANT_BIT] && !rsp_tdata[RSP_SA_V_BIT] &&
       !rsp_tdata[RSP_SB_V_BIT]))
      else $error("clear all mixed with other results");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");

endmodule

bind priority_voice_allocator pva_checker u_pva_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
